### rtl/core/label_reachability_query_top_macros.svh
// Assertion helpers used by the back-end module.
`ifndef LABEL_REACHABILITY_QUERY_TOP_MACROS_SVH
`define LABEL_REACHABILITY_QUERY_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LRQ_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lrq: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define LRQ_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lrq: next-cycle check failed");

`endif

### rtl/core/lrq_pkg.sv
package lrq_pkg;

  localparam int NUM_VERTICES = 1024;
  localparam int MAX_LABELS   = 16;
  localparam int LABEL_BITS   = 16;
  localparam int LEVEL_BITS   = 16;
  localparam int NUM_SETS     = 3;

  // port field widths
  localparam int IN_VTX_W = 10;
  localparam int IN_VAL_W = 16;
  localparam int SET_W    = 2;

  localparam int VTX_W     = $clog2(NUM_VERTICES);
  localparam int IDX_W     = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int CNT_W     = $clog2(MAX_LABELS + 1);
  localparam int LBL_AW    = SET_W + VTX_W + IDX_W;
  localparam int LBL_DEPTH = NUM_SETS * (2 ** (VTX_W + IDX_W));

  localparam logic CFG_LEVEL_FILTER = 1'b0;
  localparam logic CFG_SET_ENABLE   = 1'b1;

  typedef enum logic [1:0] {
    OP_LEVEL = 2'd0,
    OP_OUT   = 2'd1,
    OP_IN    = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  // classified item handed from front to back
  typedef struct packed {
    op_t                 op;
    logic [IN_VTX_W-1:0] vertex;
    logic [SET_W-1:0]    label_set;
    logic [IN_VAL_W-1:0] value;
    logic [IN_VTX_W-1:0] source;
    logic [IN_VTX_W-1:0] target;
    logic                vtx_ok;
    logic                set_ok;
    logic                src_ok;
    logic                dst_ok;
    logic                same;
  } cmd_t;

  typedef struct packed {
    logic reachable;
    logic pruned;
    logic status;
  } res_t;

  typedef struct packed {
    logic [NUM_SETS-1:0][CNT_W-1:0] out_cnt;
    logic [NUM_SETS-1:0][CNT_W-1:0] in_cnt;
  } cnt_row_t;

endpackage

### rtl/core/lrq_front.sv
module lrq_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          hold,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_op,
  input  logic [lrq_pkg::IN_VTX_W-1:0]  in_vertex,
  input  logic [lrq_pkg::SET_W-1:0]     in_label_set,
  input  logic [lrq_pkg::IN_VAL_W-1:0]  in_value,
  input  logic [lrq_pkg::IN_VTX_W-1:0]  in_source,
  input  logic [lrq_pkg::IN_VTX_W-1:0]  in_target,
  output logic                          cmd_valid,
  output lrq_pkg::cmd_t                 cmd,
  input  logic                          cmd_pop
);
  import lrq_pkg::*;

  cmd_t       q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       accept;
  cmd_t       cls;

  // classify on entry so the back end sees ready-made flags
  always_comb begin
    cls.op        = op_t'(in_op);
    cls.vertex    = in_vertex;
    cls.label_set = in_label_set;
    cls.value     = in_value;
    cls.source    = in_source;
    cls.target    = in_target;
    cls.vtx_ok    = 32'(in_vertex) < 32'(NUM_VERTICES);
    cls.set_ok    = 32'(in_label_set) < 32'(NUM_SETS);
    cls.src_ok    = 32'(in_source) < 32'(NUM_VERTICES);
    cls.dst_ok    = 32'(in_target) < 32'(NUM_VERTICES);
    cls.same      = in_source == in_target;
  end

  assign in_full   = (cnt_r == 2'd2) || hold;
  assign accept    = in_push && !in_full;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (accept) q_r[wr_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (accept) wr_r <= !wr_r;
      if (cmd_pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(accept) - 2'(cmd_pop);
    end
  end

endmodule

### rtl/core/lrq_back.sv
`include "label_reachability_query_top_macros.svh"

module lrq_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  lrq_pkg::cmd_t                cmd,
  output logic                         cmd_pop,
  input  logic                         filter_on,
  input  logic [lrq_pkg::NUM_SETS-1:0] set_en,
  output logic                         clearing,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic                         out_reachable,
  output logic                         out_pruned,
  output logic                         out_status
);
  import lrq_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_SETUP, S_WALK
  } state_t;

  logic [LEVEL_BITS-1:0] lvl_mem  [NUM_VERTICES];
  cnt_row_t              cnt_mem  [NUM_VERTICES];
  logic [LABEL_BITS-1:0] olbl_mem [LBL_DEPTH];
  logic [LABEL_BITS-1:0] ilbl_mem [LBL_DEPTH];

  state_t                state_r, state_nxt;
  logic [VTX_W-1:0]      clr_r;
  cmd_t                  cmd_r;
  logic [SET_W-1:0]      set_r, set_nxt;
  logic [IDX_W-1:0]      i_r, i_nxt, j_r, j_nxt;
  logic [LEVEL_BITS-1:0] lvl_a_r, lvl_b_r;
  cnt_row_t              cnt_a_r, cnt_b_r;
  logic [LABEL_BITS-1:0] a_r, b_r;

  res_t                  oq_r [2];
  logic                  oq_wr_r, oq_rd_r;
  logic [1:0]            oq_cnt_r;

  logic [VTX_W-1:0]      rd_a_idx, rd_b_idx, vtx_idx, src_idx, dst_idx;
  logic                  lvl_we, cnt_we, olbl_we, ilbl_we;
  cnt_row_t              cnt_wd;
  logic [CNT_W-1:0]      n, na, nb;
  logic [LEVEL_BITS-1:0] la, lb;
  logic [LBL_AW-1:0]     lbl_wa, olbl_ra, ilbl_ra;
  logic                  res_push;
  res_t                  res;

  assign clearing = state_r == S_CLEAR;
  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid && (oq_cnt_r != 2'd2);

  assign rd_a_idx = (cmd.op == OP_QUERY) ? VTX_W'(cmd.source) : VTX_W'(cmd.vertex);
  assign rd_b_idx = VTX_W'(cmd.target);
  assign vtx_idx  = VTX_W'(cmd_r.vertex);
  assign src_idx  = VTX_W'(cmd_r.source);
  assign dst_idx  = VTX_W'(cmd_r.target);

  assign na = cmd_r.src_ok ? cnt_a_r.out_cnt[set_r] : '0;
  assign nb = cmd_r.dst_ok ? cnt_b_r.in_cnt[set_r] : '0;
  assign la = cmd_r.src_ok ? lvl_a_r : '0;
  assign lb = cmd_r.dst_ok ? lvl_b_r : '0;
  assign n  = (cmd_r.op == OP_OUT) ? cnt_a_r.out_cnt[cmd_r.label_set]
                                   : cnt_a_r.in_cnt[cmd_r.label_set];

  assign lbl_wa  = {cmd_r.label_set, vtx_idx, IDX_W'(n)};
  assign olbl_ra = {set_r, src_idx, i_nxt};
  assign ilbl_ra = {set_r, dst_idx, j_nxt};

  always_comb begin
    state_nxt = state_r;
    set_nxt   = set_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    lvl_we    = 1'b0;
    cnt_we    = 1'b0;
    olbl_we   = 1'b0;
    ilbl_we   = 1'b0;
    cnt_wd    = cnt_a_r;
    res_push  = 1'b0;
    res       = '0;
    unique case (state_r)
      S_CLEAR: begin
        if (32'(clr_r) == 32'(NUM_VERTICES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_pop) state_nxt = S_FETCH;
      end
      S_FETCH: begin
        unique case (cmd_r.op)
          OP_LEVEL: begin
            lvl_we    = cmd_r.vtx_ok;
            res_push  = 1'b1;
            state_nxt = S_IDLE;
          end
          OP_OUT, OP_IN: begin
            res_push  = 1'b1;
            state_nxt = S_IDLE;
            if (cmd_r.vtx_ok && cmd_r.set_ok) begin
              if (32'(n) >= 32'(MAX_LABELS)) begin
                res.status = 1'b1;
              end else begin
                cnt_we = 1'b1;
                if (cmd_r.op == OP_OUT) begin
                  olbl_we = 1'b1;
                  cnt_wd.out_cnt[cmd_r.label_set] = n + CNT_W'(1);
                end else begin
                  ilbl_we = 1'b1;
                  cnt_wd.in_cnt[cmd_r.label_set] = n + CNT_W'(1);
                end
              end
            end
          end
          OP_QUERY: begin
            if (filter_on && (la >= lb)) begin
              res.pruned = 1'b1;
              res_push   = 1'b1;
              state_nxt  = S_IDLE;
            end else if (cmd_r.same && (set_en != '0)) begin
              res.reachable = 1'b1;
              res_push      = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              set_nxt   = '0;
              state_nxt = S_SETUP;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SETUP: begin
        if (32'(set_r) >= 32'(NUM_SETS)) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end else if (!set_en[set_r] || (na == '0) || (nb == '0)) begin
          set_nxt = set_r + SET_W'(1);
        end else begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (a_r == b_r) begin
          res.reachable = 1'b1;
          res_push      = 1'b1;
          state_nxt     = S_IDLE;
        end else if (a_r < b_r) begin
          if (CNT_W'(i_r) + CNT_W'(1) == na) begin
            set_nxt   = set_r + SET_W'(1);
            state_nxt = S_SETUP;
          end else begin
            i_nxt = i_r + IDX_W'(1);
          end
        end else begin
          if (CNT_W'(j_r) + CNT_W'(1) == nb) begin
            set_nxt   = set_r + SET_W'(1);
            state_nxt = S_SETUP;
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // storage: one write port, registered reads; vertex rows are captured
  // when the item is taken and held until it is done
  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[vtx_idx] <= LEVEL_BITS'(cmd_r.value);
    if (cmd_pop) begin
      lvl_a_r <= lvl_mem[rd_a_idx];
      lvl_b_r <= lvl_mem[rd_b_idx];
    end
    if (state_r == S_CLEAR) cnt_mem[clr_r] <= '0;
    else if (cnt_we) cnt_mem[vtx_idx] <= cnt_wd;
    if (cmd_pop) begin
      cnt_a_r <= cnt_mem[rd_a_idx];
      cnt_b_r <= cnt_mem[rd_b_idx];
    end
    if (olbl_we) olbl_mem[lbl_wa] <= LABEL_BITS'(cmd_r.value);
    a_r <= olbl_mem[olbl_ra];
    if (ilbl_we) ilbl_mem[lbl_wa] <= LABEL_BITS'(cmd_r.value);
    b_r <= ilbl_mem[ilbl_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cmd_r <= cmd;
    if (res_push) oq_r[oq_wr_r] <= res;
    set_r <= set_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + VTX_W'(1);
      if (res_push) oq_wr_r <= !oq_wr_r;
      if (out_pop && !out_empty) oq_rd_r <= !oq_rd_r;
      oq_cnt_r <= oq_cnt_r + 2'(res_push) - 2'(out_pop && !out_empty);
    end
  end

  assign out_empty     = oq_cnt_r == 2'd0;
  assign out_reachable = oq_r[oq_rd_r].reachable;
  assign out_pruned    = oq_r[oq_rd_r].pruned;
  assign out_status    = oq_r[oq_rd_r].status;

  // a slot is reserved when an item is taken, so a push never overflows
  `LRQ_ASSERT_IMP(a_oq_no_overflow, res_push, oq_cnt_r != 2'd2)
  `LRQ_ASSERT_IMP(a_walk_in_bounds, state_r == S_WALK, (CNT_W'(i_r) < na) && (CNT_W'(j_r) < nb))
  `LRQ_ASSERT_NXT(a_pop_to_fetch, cmd_pop, state_r == S_FETCH)

endmodule

### rtl/core/label_reachability_query_top.sv
// Channel   Handshake                 Payload
// in_       in_push / in_full         op, vertex, label_set, value, source, target
// out_      out_pop / out_empty       reachable, pruned, status
// cfg_      cfg_valid / cfg_ready     cfg_index (0 filter, 1 set mask), cfg_data
//
// In the back end a load item is taken and its rows read, then the item is
// written and its result posted. A query is fetched, then walks each enabled
// set with a merge of at most 2*MAX_LABELS-1 steps; a match ends the walk
// early, and a pruned or same-vertex query posts its result without a walk.
// After reset the count memory is swept to zero, one vertex a cycle,
// with in_full held high; config is taken throughout.
// A two-item queue parts the input from the back end, a two-item result queue
// parts it from the consumer, so either side can stall without losing items.
module label_reachability_query_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_op,
  input  logic [lrq_pkg::IN_VTX_W-1:0]  in_vertex,
  input  logic [lrq_pkg::SET_W-1:0]     in_label_set,
  input  logic [lrq_pkg::IN_VAL_W-1:0]  in_value,
  input  logic [lrq_pkg::IN_VTX_W-1:0]  in_source,
  input  logic [lrq_pkg::IN_VTX_W-1:0]  in_target,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_reachable,
  output logic                          out_pruned,
  output logic                          out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [2:0]                    cfg_data
);
  import lrq_pkg::*;

  logic                level_filter_on_r;
  logic [NUM_SETS-1:0] label_set_enable_r;
  logic                clearing;
  logic                cmd_valid;
  logic                cmd_pop;
  cmd_t                cmd;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_filter_on_r  <= 1'b0;
      label_set_enable_r <= NUM_SETS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEVEL_FILTER: level_filter_on_r  <= cfg_data[0];
        CFG_SET_ENABLE:   label_set_enable_r <= cfg_data[NUM_SETS-1:0];
        default: ;
      endcase
    end
  end

  // front end: item queue and classification
  lrq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .hold         (clearing),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_op        (in_op),
    .in_vertex    (in_vertex),
    .in_label_set (in_label_set),
    .in_value     (in_value),
    .in_source    (in_source),
    .in_target    (in_target),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // back end: label store, level table, merge walk, result queue
  lrq_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .filter_on     (level_filter_on_r),
    .set_en        (label_set_enable_r),
    .clearing      (clearing),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_reachable (out_reachable),
    .out_pruned    (out_pruned),
    .out_status    (out_status)
  );

endmodule
